>>> rtl/core/assert_macros.svh
// assertion helpers used by julia_set_escape_pixel
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

>>> rtl/core/jsep_pkg.sv
package jsep_pkg;

   // number format
   localparam int FRAC_BITS  = 24;
   localparam int COORD_BITS = 12;
   localparam int Q_W        = 16 + FRAC_BITS;
   localparam int LO_W       = Q_W / 2;
   localparam int HI_W       = Q_W - LO_W;
   localparam int PROD_W     = HI_W + Q_W;
   localparam int ACC_W      = 2 * Q_W;
   localparam int RES_W      = ACC_W - FRAC_BITS + 2;
   localparam int SUM_W      = RES_W + 2;
   localparam int DIVD_W     = COORD_BITS + FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIVD_W);

   // register widths
   localparam int CONST_W = 26;
   localparam int ITER_W  = 10;
   localparam int LIMIT_W = 16;
   localparam int CSR_W   = 26;
   localparam int CSR_IDX_W = 3;
   localparam int COLOR_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_C_REAL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IMAG    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_LIMIT = 3'd5;

   // register reset values
   localparam logic [COORD_BITS-1:0]     NUM_ROWS_RST  = 12'd1080;
   localparam logic [COORD_BITS-1:0]     NUM_COLS_RST  = 12'd1920;
   localparam logic signed [CONST_W-1:0] C_REAL_RST    = -26'sd13421773;
   localparam logic signed [CONST_W-1:0] C_IMAG_RST    = 26'sd2617246;
   localparam logic [ITER_W-1:0]         MAX_ITER_RST  = 10'd200;
   localparam logic [LIMIT_W-1:0]        ESC_LIMIT_RST = 16'd1000;

   // inside colour
   localparam logic [COLOR_W-1:0] INSIDE_RED   = 8'd51;
   localparam logic [COLOR_W-1:0] INSIDE_GREEN = 8'd102;
   localparam logic [COLOR_W-1:0] INSIDE_BLUE  = 8'd178;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RE_DIV_GO,
      ST_RE_DIV_WAIT,
      ST_IM_DIV_GO,
      ST_IM_DIV_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_UPDATE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_RR,
      OP_II,
      OP_RI
   } mul_op_type;

   typedef struct packed {
      logic start;
      logic half_shift;
   } mul_ctrl_type;

endpackage

>>> rtl/core/jsep_div.sv
// restoring divider, one quotient bit per cycle
// quotient = (mag << FRAC_BITS) / divisor
module jsep_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [jsep_pkg::COORD_BITS-1:0]   mag,
   input  logic [jsep_pkg::COORD_BITS-1:0]   divisor,
   output logic                              done,
   output logic [jsep_pkg::DIVD_W-1:0]       quot
);

   logic                                running_ff, running_in;
   logic                                done_ff, done_in;
   logic [jsep_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [jsep_pkg::COORD_BITS-1:0]     rem_ff, rem_in;
   logic [jsep_pkg::COORD_BITS-1:0]     dvs_ff, dvs_in;
   logic [jsep_pkg::DIVD_W-1:0]         q_ff, q_in;
   logic [jsep_pkg::COORD_BITS:0]       trial;
   logic                                fits;

   // one shift-subtract step
   always_comb begin
      trial = {rem_ff, q_ff[jsep_pkg::DIVD_W-1]};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      q_in       = q_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         dvs_in     = divisor;
         q_in       = {mag, {jsep_pkg::FRAC_BITS{1'b0}}};
      end else if (running_ff) begin
         rem_in = fits ? jsep_pkg::COORD_BITS'(trial - {1'b0, dvs_ff})
                       : jsep_pkg::COORD_BITS'(trial);
         q_in   = {q_ff[jsep_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == jsep_pkg::DIV_CNT_W'(jsep_pkg::DIVD_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> rtl/core/jsep_mul.sv
// shared fixed point multiplier: two partial products of a half by a full
// magnitude, then a floored shift by FRAC_BITS, one less with half_shift
module jsep_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  jsep_pkg::mul_ctrl_type               ctrl,
   input  logic signed [jsep_pkg::Q_W-1:0]      op_a,
   input  logic signed [jsep_pkg::Q_W-1:0]      op_b,
   output logic                                 done,
   output logic signed [jsep_pkg::RES_W-1:0]    result
);

   logic                                 running_ff, running_in;
   logic                                 done_ff, done_in;
   logic [1:0]                           step_ff, step_in;
   logic [jsep_pkg::Q_W-1:0]             a_mag_ff, a_mag_in;
   logic [jsep_pkg::Q_W-1:0]             b_mag_ff, b_mag_in;
   logic                                 neg_ff, neg_in;
   logic                                 half_ff, half_in;
   logic [jsep_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic [jsep_pkg::ACC_W-1:0]           acc_ff, acc_in;
   logic signed [jsep_pkg::RES_W-1:0]    res_ff, res_in;
   logic [jsep_pkg::HI_W-1:0]            a_part;
   logic signed [jsep_pkg::ACC_W:0]      signed_acc;
   logic signed [jsep_pkg::ACC_W:0]      shifted;

   // partial product of the selected half of a by all of b
   always_comb begin
      a_part  = step_ff[0] ? a_mag_ff[jsep_pkg::Q_W-1:jsep_pkg::LO_W]
                           : jsep_pkg::HI_W'(a_mag_ff[jsep_pkg::LO_W-1:0]);
      prod_in = a_part * b_mag_ff;
   end

   // sign the exact product and floor it
   always_comb begin
      signed_acc = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
      shifted    = half_ff ? (signed_acc >>> (jsep_pkg::FRAC_BITS - 1))
                           : (signed_acc >>> jsep_pkg::FRAC_BITS);
   end

   // step sequencer
   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      a_mag_in   = a_mag_ff;
      b_mag_in   = b_mag_ff;
      neg_in     = neg_ff;
      half_in    = half_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      if (ctrl.start) begin
         running_in = 1'b1;
         step_in    = 2'd0;
         acc_in     = '0;
         a_mag_in   = op_a[jsep_pkg::Q_W-1] ? jsep_pkg::Q_W'(-op_a) : op_a;
         b_mag_in   = op_b[jsep_pkg::Q_W-1] ? jsep_pkg::Q_W'(-op_b) : op_b;
         neg_in     = op_a[jsep_pkg::Q_W-1] ^ op_b[jsep_pkg::Q_W-1];
         half_in    = ctrl.half_shift;
      end else if (running_ff) begin
         case (step_ff)
            2'd0: begin
               step_in = 2'd1;
            end
            2'd1: begin
               acc_in  = acc_ff + jsep_pkg::ACC_W'(prod_ff);
               step_in = 2'd2;
            end
            2'd2: begin
               acc_in  = acc_ff + (jsep_pkg::ACC_W'(prod_ff) << jsep_pkg::LO_W);
               step_in = 2'd3;
            end
            default: begin
               res_in     = shifted[jsep_pkg::RES_W-1:0];
               running_in = 1'b0;
               done_in    = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         step_ff    <= 2'd0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         step_ff    <= step_in;
      end
      a_mag_ff <= a_mag_in;
      b_mag_ff <= b_mag_in;
      neg_ff   <= neg_in;
      half_ff  <= half_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> rtl/core/julia_set_escape_pixel.sv
// channel | ports                                  | transaction moves
// --------+----------------------------------------+---------------------------------
// req     | req_valid req_ready req_row req_col    | one pixel position
// rsp     | rsp_valid rsp_ready rsp_inside_res     | verdict and colour of one pixel
//         | rsp_red rsp_green rsp_blue             |
// csr     | csr_wr_en csr_index csr_wdata          | one register write, no wait
//
// one pixel runs two 36-step divisions that set the start point, then n iterations,
// n the iterations run before escape or the budget runs out; each iteration is
// three products through the one shared multiplier.
// req_ready is high only while idle; a finished result waits in the output
// register, and a new pixel is taken meanwhile but not finished until rsp drains.
// reset is synchronous and restores the register defaults.
`include "assert_macros.svh"
module julia_set_escape_pixel (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [jsep_pkg::COORD_BITS-1:0]      req_row,
   input  logic [jsep_pkg::COORD_BITS-1:0]      req_col,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_inside_res,
   output logic [jsep_pkg::COLOR_W-1:0]         rsp_red,
   output logic [jsep_pkg::COLOR_W-1:0]         rsp_green,
   output logic [jsep_pkg::COLOR_W-1:0]         rsp_blue,
   input  logic                                 csr_wr_en,
   input  logic [jsep_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [jsep_pkg::CSR_W-1:0]           csr_wdata
);

   localparam logic signed [jsep_pkg::Q_W-1:0] Q_MAX =
      {1'b0, {(jsep_pkg::Q_W-1){1'b1}}};
   localparam logic signed [jsep_pkg::Q_W-1:0] Q_MIN =
      {1'b1, {(jsep_pkg::Q_W-1){1'b0}}};
   localparam logic signed [jsep_pkg::SUM_W-1:0] SUM_QMAX = jsep_pkg::SUM_W'(Q_MAX);
   localparam logic signed [jsep_pkg::SUM_W-1:0] SUM_QMIN = jsep_pkg::SUM_W'(Q_MIN);

   // clamp to the z component range
   function automatic logic signed [jsep_pkg::Q_W-1:0] sat_q(
      input logic signed [jsep_pkg::SUM_W-1:0] v
   );
      if (v > SUM_QMAX) begin
         return Q_MAX;
      end else if (v < SUM_QMIN) begin
         return Q_MIN;
      end
      return v[jsep_pkg::Q_W-1:0];
   endfunction

   jsep_pkg::state_type                   state_ff, state_in;
   jsep_pkg::mul_op_type                  op_ff, op_in;

   logic [jsep_pkg::COORD_BITS-1:0]       num_rows_ff, num_rows_in;
   logic [jsep_pkg::COORD_BITS-1:0]       num_cols_ff, num_cols_in;
   logic signed [jsep_pkg::CONST_W-1:0]   c_real_ff, c_real_in;
   logic signed [jsep_pkg::CONST_W-1:0]   c_imag_ff, c_imag_in;
   logic [jsep_pkg::ITER_W-1:0]           max_iter_ff, max_iter_in;
   logic [jsep_pkg::LIMIT_W-1:0]          esc_limit_ff, esc_limit_in;

   logic [jsep_pkg::COORD_BITS-1:0]       row_ff, row_in;
   logic [jsep_pkg::COORD_BITS-1:0]       col_ff, col_in;
   logic                                  coord_neg_ff, coord_neg_in;
   logic signed [jsep_pkg::Q_W-1:0]       re_ff, re_in;
   logic signed [jsep_pkg::Q_W-1:0]       im_ff, im_in;
   logic signed [jsep_pkg::RES_W-1:0]     rr_ff, rr_in;
   logic signed [jsep_pkg::RES_W-1:0]     ii_ff, ii_in;
   logic signed [jsep_pkg::RES_W-1:0]     ri_ff, ri_in;
   logic [jsep_pkg::ITER_W-1:0]           k_ff, k_in;
   logic                                  verdict_ff, verdict_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_inside_ff, rsp_inside_in;

   logic                                  req_accept;
   logic                                  rsp_slot_free;
   logic [jsep_pkg::COORD_BITS-1:0]       coord_idx;
   logic [jsep_pkg::COORD_BITS-1:0]       coord_count;
   logic [jsep_pkg::COORD_BITS-1:0]       half_cnt;
   logic signed [jsep_pkg::COORD_BITS:0]  coord_diff;
   logic [jsep_pkg::COORD_BITS-1:0]       div_mag;
   logic [jsep_pkg::COORD_BITS-1:0]       div_divisor;
   logic                                  div_start;
   logic                                  div_done;
   logic [jsep_pkg::DIVD_W-1:0]           div_quot;
   logic signed [jsep_pkg::Q_W-1:0]       quot_pos;
   logic signed [jsep_pkg::Q_W-1:0]       start_coord;
   jsep_pkg::mul_ctrl_type                mul_ctrl;
   logic signed [jsep_pkg::Q_W-1:0]       mul_a;
   logic signed [jsep_pkg::Q_W-1:0]       mul_b;
   logic                                  mul_done;
   logic signed [jsep_pkg::RES_W-1:0]     mul_res;
   logic signed [jsep_pkg::SUM_W-1:0]     re_sum;
   logic signed [jsep_pkg::SUM_W-1:0]     im_sum;
   logic signed [jsep_pkg::RES_W:0]       mag_sum;
   logic signed [jsep_pkg::RES_W:0]       bound;
   logic                                  escape;
   logic                                  budget_spent;

   assign req_accept    = req_valid && req_ready;
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   // configuration writes
   always_comb begin
      num_rows_in  = num_rows_ff;
      num_cols_in  = num_cols_ff;
      c_real_in    = c_real_ff;
      c_imag_in    = c_imag_ff;
      max_iter_in  = max_iter_ff;
      esc_limit_in = esc_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            jsep_pkg::CSR_NUM_ROWS:  num_rows_in  = csr_wdata[jsep_pkg::COORD_BITS-1:0];
            jsep_pkg::CSR_NUM_COLS:  num_cols_in  = csr_wdata[jsep_pkg::COORD_BITS-1:0];
            jsep_pkg::CSR_C_REAL:    c_real_in    = csr_wdata[jsep_pkg::CONST_W-1:0];
            jsep_pkg::CSR_C_IMAG:    c_imag_in    = csr_wdata[jsep_pkg::CONST_W-1:0];
            jsep_pkg::CSR_MAX_ITER:  max_iter_in  = csr_wdata[jsep_pkg::ITER_W-1:0];
            jsep_pkg::CSR_ESC_LIMIT: esc_limit_in = csr_wdata[jsep_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // start point operands for the divider
   always_comb begin
      coord_idx   = (state_ff == jsep_pkg::ST_RE_DIV_GO) ? row_ff : col_ff;
      coord_count = (state_ff == jsep_pkg::ST_RE_DIV_GO) ? num_rows_ff : num_cols_ff;
      half_cnt    = coord_count >> 1;
      if (half_cnt == '0) begin
         half_cnt = jsep_pkg::COORD_BITS'(1);
      end
      coord_diff  = $signed({1'b0, half_cnt}) - $signed({1'b0, coord_idx});
      div_mag     = coord_diff[jsep_pkg::COORD_BITS] ?
                    jsep_pkg::COORD_BITS'(-coord_diff) :
                    jsep_pkg::COORD_BITS'(coord_diff);
      div_divisor = {half_cnt[jsep_pkg::COORD_BITS-2:0], 1'b0};
      quot_pos    = $signed(jsep_pkg::Q_W'(div_quot));
      start_coord = coord_neg_ff ? -quot_pos : quot_pos;
   end

   // multiplier operand select
   always_comb begin
      mul_a = (op_ff == jsep_pkg::OP_II) ? im_ff : re_ff;
      mul_b = (op_ff == jsep_pkg::OP_RR) ? re_ff : im_ff;
   end

   // update and escape arithmetic
   always_comb begin
      re_sum  = jsep_pkg::SUM_W'(rr_ff) - jsep_pkg::SUM_W'(ii_ff)
              + jsep_pkg::SUM_W'(c_real_ff);
      im_sum  = jsep_pkg::SUM_W'(ri_ff) + jsep_pkg::SUM_W'(c_imag_ff);
      mag_sum = (jsep_pkg::RES_W+1)'(rr_ff) + (jsep_pkg::RES_W+1)'(ii_ff);
      bound   = $signed((jsep_pkg::RES_W+1)'({esc_limit_ff,
                                              {jsep_pkg::FRAC_BITS{1'b0}}}));
      escape       = mag_sum > bound;
      budget_spent = (k_ff == max_iter_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jsep_pkg::ST_IDLE: begin
            if (req_valid) state_in = jsep_pkg::ST_RE_DIV_GO;
         end
         jsep_pkg::ST_RE_DIV_GO: state_in = jsep_pkg::ST_RE_DIV_WAIT;
         jsep_pkg::ST_RE_DIV_WAIT: begin
            if (div_done) state_in = jsep_pkg::ST_IM_DIV_GO;
         end
         jsep_pkg::ST_IM_DIV_GO: state_in = jsep_pkg::ST_IM_DIV_WAIT;
         jsep_pkg::ST_IM_DIV_WAIT: begin
            if (div_done) begin
               state_in = (max_iter_ff == '0) ? jsep_pkg::ST_FINISH : jsep_pkg::ST_MUL_GO;
            end
         end
         jsep_pkg::ST_MUL_GO: state_in = jsep_pkg::ST_MUL_WAIT;
         jsep_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               if (op_ff == jsep_pkg::OP_RI) begin
                  state_in = (k_ff == '0) ? jsep_pkg::ST_UPDATE : jsep_pkg::ST_CHECK;
               end else begin
                  state_in = jsep_pkg::ST_MUL_GO;
               end
            end
         end
         jsep_pkg::ST_UPDATE: state_in = jsep_pkg::ST_MUL_GO;
         jsep_pkg::ST_CHECK: begin
            state_in = (escape || budget_spent) ? jsep_pkg::ST_FINISH : jsep_pkg::ST_UPDATE;
         end
         jsep_pkg::ST_FINISH: begin
            if (rsp_slot_free) state_in = jsep_pkg::ST_IDLE;
         end
         default: state_in = jsep_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready           = (state_ff == jsep_pkg::ST_IDLE);
      div_start           = (state_ff == jsep_pkg::ST_RE_DIV_GO) ||
                            (state_ff == jsep_pkg::ST_IM_DIV_GO);
      mul_ctrl.start      = (state_ff == jsep_pkg::ST_MUL_GO);
      mul_ctrl.half_shift = (op_ff == jsep_pkg::OP_RI);
   end

   // datapath registers
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      coord_neg_in  = coord_neg_ff;
      re_in         = re_ff;
      im_in         = im_ff;
      rr_in         = rr_ff;
      ii_in         = ii_ff;
      ri_in         = ri_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      verdict_in    = verdict_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         jsep_pkg::ST_IDLE: begin
            if (req_accept) begin
               row_in = req_row;
               col_in = req_col;
            end
         end
         jsep_pkg::ST_RE_DIV_GO, jsep_pkg::ST_IM_DIV_GO: begin
            coord_neg_in = coord_diff[jsep_pkg::COORD_BITS];
         end
         jsep_pkg::ST_RE_DIV_WAIT: begin
            if (div_done) re_in = start_coord;
         end
         jsep_pkg::ST_IM_DIV_WAIT: begin
            if (div_done) begin
               im_in      = start_coord;
               k_in       = '0;
               op_in      = jsep_pkg::OP_RR;
               verdict_in = 1'b1;
            end
         end
         jsep_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  jsep_pkg::OP_RR: begin
                     rr_in = mul_res;
                     op_in = jsep_pkg::OP_II;
                  end
                  jsep_pkg::OP_II: begin
                     ii_in = mul_res;
                     op_in = jsep_pkg::OP_RI;
                  end
                  default: begin
                     ri_in = mul_res;
                     op_in = jsep_pkg::OP_RR;
                  end
               endcase
            end
         end
         jsep_pkg::ST_UPDATE: begin
            re_in = sat_q(re_sum);
            im_in = sat_q(im_sum);
            k_in  = k_ff + 1'b1;
            op_in = jsep_pkg::OP_RR;
         end
         jsep_pkg::ST_CHECK: begin
            verdict_in = !escape;
         end
         jsep_pkg::ST_FINISH: begin
            if (rsp_slot_free) begin
               rsp_inside_in = verdict_ff;
               rsp_valid_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jsep_pkg::ST_IDLE;
         op_ff        <= jsep_pkg::OP_RR;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         num_rows_ff  <= jsep_pkg::NUM_ROWS_RST;
         num_cols_ff  <= jsep_pkg::NUM_COLS_RST;
         c_real_ff    <= jsep_pkg::C_REAL_RST;
         c_imag_ff    <= jsep_pkg::C_IMAG_RST;
         max_iter_ff  <= jsep_pkg::MAX_ITER_RST;
         esc_limit_ff <= jsep_pkg::ESC_LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         num_rows_ff  <= num_rows_in;
         num_cols_ff  <= num_cols_in;
         c_real_ff    <= c_real_in;
         c_imag_ff    <= c_imag_in;
         max_iter_ff  <= max_iter_in;
         esc_limit_ff <= esc_limit_in;
      end
      row_ff        <= row_in;
      col_ff        <= col_in;
      coord_neg_ff  <= coord_neg_in;
      re_ff         <= re_in;
      im_ff         <= im_in;
      rr_ff         <= rr_in;
      ii_ff         <= ii_in;
      ri_ff         <= ri_in;
      verdict_ff    <= verdict_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   // start point divider
   jsep_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .mag     (div_mag),
      .divisor (div_divisor),
      .done    (div_done),
      .quot    (div_quot)
   );

   // shared multiplier
   jsep_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mul_ctrl),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // result outputs
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_red        = rsp_inside_ff ? jsep_pkg::INSIDE_RED   : '0;
   assign rsp_green      = rsp_inside_ff ? jsep_pkg::INSIDE_GREEN : '0;
   assign rsp_blue       = rsp_inside_ff ? jsep_pkg::INSIDE_BLUE  : '0;

   // sequencer checks
   `ASSERT_IMPLIES(a_div_done_in_wait, clock, reset, div_done, (state_ff == jsep_pkg::ST_RE_DIV_WAIT) || (state_ff == jsep_pkg::ST_IM_DIV_WAIT))
   `ASSERT_IMPLIES(a_mul_done_in_wait, clock, reset, mul_done, state_ff == jsep_pkg::ST_MUL_WAIT)
   `ASSERT_IMPLIES(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == jsep_pkg::ST_FINISH)
   `ASSERT_NEXT(a_accept_starts_div, clock, reset, req_valid && req_ready, state_ff == jsep_pkg::ST_RE_DIV_GO)

endmodule
